>>> rtl/core/rvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvt_pkg
// shared types and constants of the ray voxel traversal block
// ----------------------------------------------------------------------------
package rvt_pkg;

    localparam int FIELD_W  = 16;
    localparam int IN_W     = 6 * FIELD_W;
    localparam int OUT_W    = 4 * FIELD_W;
    localparam int USER_W   = 2;
    localparam int CFG_IDX_W = 2;
    // coordinates and their differences, wide enough for any input pattern
    localparam int EXT_W    = FIELD_W + 2;
    localparam int ABS_W    = FIELD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_FREE_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OCC_INC  = 2'd1;

    localparam logic [FIELD_W-1:0] FREE_INC_RESET = 16'hFF27;
    localparam logic [FIELD_W-1:0] OCC_INC_RESET  = 16'h0232;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIFF = 4'b0010,
        ST_AXIS = 4'b0100,
        ST_RUN  = 4'b1000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic calc_diff;
        logic calc_axis;
        logic emit_step;
        logic emit_end;
        logic emit_long;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic too_long;
        logic at_end;
    } sts_t;

endpackage

>>> rtl/core/rvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvt_ctrl
// sequencer: request capture, setup steps and one result per free output slot
// ----------------------------------------------------------------------------
module rvt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rvt_pkg::sts_t sts,
    output rvt_pkg::cmd_t cmd
);

    rvt_pkg::state_t state_reg;
    rvt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rvt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == rvt_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            rvt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = rvt_pkg::ST_DIFF;
                end
            end
            rvt_pkg::ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = rvt_pkg::ST_AXIS;
            end
            rvt_pkg::ST_AXIS:
            begin
                cmd.calc_axis = 1'b1;
                state_next    = rvt_pkg::ST_RUN;
            end
            rvt_pkg::ST_RUN:
            begin
                if (sts.out_free)
                begin
                    if (sts.too_long)
                    begin
                        cmd.emit_long = 1'b1;
                        state_next    = rvt_pkg::ST_IDLE;
                    end
                    else if (sts.at_end)
                    begin
                        cmd.emit_end = 1'b1;
                        state_next   = rvt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = rvt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/rvt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvt_dp
// datapath: config registers, axis selection, error terms, voxel stepping and output register
// ----------------------------------------------------------------------------
module rvt_dp
#(
    parameter int MAX_SPAN   = 63,
    parameter int COORD_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rvt_pkg::cmd_t                     cmd,
    output rvt_pkg::sts_t                     sts,
    input  logic [rvt_pkg::IN_W-1:0]          in_data,
    input  logic                              cfg_write,
    input  logic [rvt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rvt_pkg::FIELD_W-1:0]       cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rvt_pkg::OUT_W-1:0]         out_data,
    output logic                              out_last,
    output logic [rvt_pkg::USER_W-1:0]        out_user
);

    localparam int CNT_W    = (MAX_SPAN < 2) ? 1 : $clog2(MAX_SPAN + 1);
    localparam int PW       = CNT_W + 3;
    localparam bit SIGN_EN  = (COORD_BITS <= rvt_pkg::FIELD_W);
    localparam int SIGN_POS = SIGN_EN ? COORD_BITS - 1 : rvt_pkg::FIELD_W - 1;
    localparam int FW       = rvt_pkg::FIELD_W;
    localparam int EW       = rvt_pkg::EXT_W;
    localparam int AW       = rvt_pkg::ABS_W;

    function automatic logic [EW-1:0] ext(input logic [FW-1:0] v);
        logic [EW-1:0] r;
        for (int i = 0; i < FW; i++)
        begin
            if (i < COORD_BITS)
                r[i] = v[i];
            else
                r[i] = v[SIGN_POS];
        end
        for (int i = FW; i < EW; i++)
        begin
            r[i] = SIGN_EN ? v[SIGN_POS] : 1'b0;
        end
        return r;
    endfunction

    logic [FW-1:0]        free_inc_reg;
    logic [FW-1:0]        occ_inc_reg;
    logic [EW-1:0]        start_reg [3];
    logic [EW-1:0]        end_reg   [3];
    logic [FW-1:0]        cur_reg   [3];
    logic [AW-1:0]        abs_reg   [3];
    logic                 neg_reg   [3];
    logic signed [PW-1:0] err_reg   [3];
    logic [2:0]           lead_reg;
    logic [CNT_W-1:0]     span_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 long_reg;

    logic                 out_valid_reg;
    logic [rvt_pkg::OUT_W-1:0]  out_data_reg;
    logic                 out_last_reg;
    logic [rvt_pkg::USER_W-1:0] out_user_reg;

    logic [EW-1:0]        diff      [3];
    logic                 lead_x;
    logic                 lead_y;
    logic [AW-1:0]        span_full;
    logic [PW-1:0]        span2;
    logic                 load_out;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = end_reg[i] - start_reg[i];
        end
    end

    assign lead_x = (abs_reg[0] >= abs_reg[1]) && (abs_reg[0] > abs_reg[2]);
    assign lead_y = !lead_x && (abs_reg[1] >= abs_reg[0]) && (abs_reg[1] > abs_reg[2]);
    assign span_full = lead_x ? abs_reg[0] : (lead_y ? abs_reg[1] : abs_reg[2]);
    assign span2 = PW'(span_reg) << 1;
    assign load_out = cmd.emit_step || cmd.emit_end || cmd.emit_long;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_inc_reg <= rvt_pkg::FREE_INC_RESET;
            occ_inc_reg  <= rvt_pkg::OCC_INC_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == rvt_pkg::REG_FREE_INC)
                free_inc_reg <= cfg_data;
            else if (cfg_index == rvt_pkg::REG_OCC_INC)
                occ_inc_reg <= cfg_data;
        end
    end

    // walk state
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.load_in)
            begin
                start_reg[i] <= ext(in_data[i*FW +: FW]);
                end_reg[i]   <= ext(in_data[(i+3)*FW +: FW]);
                cur_reg[i]   <= FW'(ext(in_data[i*FW +: FW]));
            end
            if (cmd.calc_diff)
            begin
                neg_reg[i] <= !(!diff[i][EW-1] && (diff[i] != '0));
                if (!diff[i][EW-1] && (diff[i] != '0))
                    abs_reg[i] <= diff[i][AW-1:0];
                else
                    abs_reg[i] <= AW'(EW'(0) - diff[i]);
            end
            if (cmd.calc_axis)
            begin
                err_reg[i] <= $signed((PW'(abs_reg[i][CNT_W-1:0]) << 1)
                                      - PW'(span_full[CNT_W-1:0]));
            end
            if (cmd.emit_step)
            begin
                if (lead_reg[i])
                begin
                    cur_reg[i] <= cur_reg[i] + (neg_reg[i] ? {FW{1'b1}} : FW'(1));
                end
                else if (err_reg[i] >= 0)
                begin
                    cur_reg[i] <= cur_reg[i] + (neg_reg[i] ? {FW{1'b1}} : FW'(1));
                    err_reg[i] <= $signed(PW'(err_reg[i]) - span2
                                          + (PW'(abs_reg[i][CNT_W-1:0]) << 1));
                end
                else
                begin
                    err_reg[i] <= $signed(PW'(err_reg[i])
                                          + (PW'(abs_reg[i][CNT_W-1:0]) << 1));
                end
            end
        end
        if (cmd.calc_axis)
        begin
            lead_reg <= {!lead_x && !lead_y, lead_y, lead_x};
            span_reg <= span_full[CNT_W-1:0];
            long_reg <= (span_full > AW'(MAX_SPAN));
            cnt_reg  <= '0;
        end
        else if (cmd.emit_step)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.too_long = long_reg;
    assign sts.at_end   = (cnt_reg == span_reg);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_step)
        begin
            out_data_reg <= {free_inc_reg, cur_reg[2], cur_reg[1], cur_reg[0]};
            out_last_reg <= 1'b0;
            out_user_reg <= 2'b00;
        end
        else if (cmd.emit_end)
        begin
            out_data_reg <= {occ_inc_reg, end_reg[2][FW-1:0], end_reg[1][FW-1:0],
                             end_reg[0][FW-1:0]};
            out_last_reg <= 1'b1;
            out_user_reg <= 2'b01;
        end
        else if (cmd.emit_long)
        begin
            out_data_reg <= '0;
            out_last_reg <= 1'b1;
            out_user_reg <= 2'b10;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
    assign out_user  = out_user_reg;

endmodule

>>> rtl/core/ray_voxel_traversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_voxel_traversal
// 3d bresenham walk of one ray, one voxel update per cycle while the output is taken
// the request is captured, the differences and then the lead axis and error terms are registered
// a ray gives span + 1 results, one per cycle while the output is taken
// a new ray is taken only after the last result of the previous one, following the setup steps and the walk
// an overlong ray gives one flagged result
// reset: asynchronous, increments return to -217 and 562, output empties
// ----------------------------------------------------------------------------
module ray_voxel_traversal
#(
    parameter int MAX_SPAN   = 63,
    parameter int COORD_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [rvt_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // voxel_x, voxel_y, voxel_z, increment
    output logic [rvt_pkg::OUT_W-1:0]     m_tdata,
    output logic                          m_tlast,
    // is_hit, too_long
    output logic [rvt_pkg::USER_W-1:0]    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rvt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rvt_pkg::FIELD_W-1:0]   cfg_data
);

    rvt_pkg::cmd_t cmd;
    rvt_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    rvt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rvt_dp
    #(
        .MAX_SPAN   (MAX_SPAN),
        .COORD_BITS (COORD_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_user  (m_tuser)
    );

endmodule

>>> tb/ray_voxel_traversal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_voxel_traversal_tb
// drives directed and random rays through the walker, predicts each voxel
// update with a bresenham walk of its own and checks every result in order,
// with random stalls on both streams and increment changes between phases
// ----------------------------------------------------------------------------
module ray_voxel_traversal_tb;

    localparam int MAX_SPAN     = 63;
    localparam int COORD_BITS   = 16;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = MAX_SPAN + 8;
    localparam int MAX_REPORTS  = 10;

    // indexes with no register behind them
    localparam logic [rvt_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [rvt_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // start point in the low half, x first, as on s_tdata
    typedef struct packed {
        logic [2:0][rvt_pkg::FIELD_W-1:0] end_pt;
        logic [2:0][rvt_pkg::FIELD_W-1:0] start_pt;
    } ray_t;

    typedef struct packed {
        logic [rvt_pkg::FIELD_W-1:0] vx;
        logic [rvt_pkg::FIELD_W-1:0] vy;
        logic [rvt_pkg::FIELD_W-1:0] vz;
        logic [rvt_pkg::FIELD_W-1:0] inc;
        logic                        hit;
        logic                        last;
        logic                        too_long;
    } voxel_t;

    class ray_walk_board;
        voxel_t                      voxel_q[$];
        logic [rvt_pkg::FIELD_W-1:0] free_inc;
        logic [rvt_pkg::FIELD_W-1:0] occ_inc;
        int                          errors;

        function new();
            free_inc = rvt_pkg::FREE_INC_RESET;
            occ_inc  = rvt_pkg::OCC_INC_RESET;
            errors   = 0;
        endfunction

        function void write_reg(logic [rvt_pkg::CFG_IDX_W-1:0] idx,
                                logic [rvt_pkg::FIELD_W-1:0] val);
            if (idx == rvt_pkg::REG_FREE_INC)
                free_inc = val;
            else if (idx == rvt_pkg::REG_OCC_INC)
                occ_inc = val;
        endfunction

        function int pending();
            return voxel_q.size();
        endfunction

        // walk the ray along its dominant axis and queue every voxel update
        function void note_ray(ray_t r);
            int     s [3];
            int     e [3];
            int     sg [3];
            int     ab [3];
            int     d [3];
            int     lead;
            int     m1;
            int     m2;
            int     span;
            int     p1;
            int     p2;
            voxel_t v;
            for (int k = 0; k < 3; k++)
            begin
                s[k]  = $signed(r.start_pt[k]);
                e[k]  = $signed(r.end_pt[k]);
                sg[k] = (e[k] - s[k] > 0) ? 1 : -1;
                ab[k] = sg[k] * (e[k] - s[k]);
                d[k]  = 0;
            end
            if (ab[0] >= ab[1] && ab[0] > ab[2])
            begin
                lead = 0;
                m1   = 1;
                m2   = 2;
            end
            else if (ab[1] >= ab[0] && ab[1] > ab[2])
            begin
                lead = 1;
                m1   = 0;
                m2   = 2;
            end
            else
            begin
                lead = 2;
                m1   = 1;
                m2   = 0;
            end
            span = ab[lead];
            if (span > MAX_SPAN)
            begin
                v          = '0;
                v.last     = 1'b1;
                v.too_long = 1'b1;
                voxel_q.push_back(v);
            end
            else
            begin
                p1 = 2 * ab[m1] - span;
                p2 = 2 * ab[m2] - span;
                while ((d[lead] < 0 ? -d[lead] : d[lead]) < span)
                begin
                    v     = '0;
                    v.vx  = 16'(s[0] + d[0]);
                    v.vy  = 16'(s[1] + d[1]);
                    v.vz  = 16'(s[2] + d[2]);
                    v.inc = free_inc;
                    voxel_q.push_back(v);
                    if (p1 >= 0)
                    begin
                        d[m1] += sg[m1];
                        p1    -= 2 * span;
                    end
                    if (p2 >= 0)
                    begin
                        d[m2] += sg[m2];
                        p2    -= 2 * span;
                    end
                    p1      += 2 * ab[m1];
                    p2      += 2 * ab[m2];
                    d[lead] += sg[lead];
                end
                v      = '0;
                v.vx   = r.end_pt[0];
                v.vy   = r.end_pt[1];
                v.vz   = r.end_pt[2];
                v.inc  = occ_inc;
                v.hit  = 1'b1;
                v.last = 1'b1;
                voxel_q.push_back(v);
            end
        endfunction

        function string show(voxel_t v);
            return $sformatf("(%0d,%0d,%0d) inc %0d hit %0b last %0b too_long %0b",
                             $signed(v.vx), $signed(v.vy), $signed(v.vz),
                             $signed(v.inc), v.hit, v.last, v.too_long);
        endfunction

        function void report_bad(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%t mismatch: %s", $realtime, msg);
        endfunction

        function void check_result(voxel_t got);
            voxel_t want;
            if (voxel_q.size() == 0)
                report_bad({"unexpected ", show(got)});
            else
            begin
                want = voxel_q.pop_front();
                if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                    got.inc !== want.inc || got.hit !== want.hit ||
                    got.last !== want.last || got.too_long !== want.too_long)
                    report_bad({"expected ", show(want), " got ", show(got)});
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [rvt_pkg::IN_W-1:0]          s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [rvt_pkg::OUT_W-1:0]         m_tdata;
    logic                              m_tlast;
    logic [rvt_pkg::USER_W-1:0]        m_tuser;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [rvt_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [rvt_pkg::FIELD_W-1:0]       cfg_data;

    ray_walk_board board;
    voxel_t        rx_voxel;
    logic          calm        = 1'b0;
    logic          hold_toggle = 1'b0;
    logic          hold_ack    = 1'b0;
    int            hold_left   = 0;
    int            quiet_cycles = 0;

    ray_voxel_traversal #(
        .MAX_SPAN   (MAX_SPAN),
        .COORD_BITS (COORD_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result side: check each taken result, random backpressure, long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                rx_voxel.vx       = m_tdata[15:0];
                rx_voxel.vy       = m_tdata[31:16];
                rx_voxel.vz       = m_tdata[47:32];
                rx_voxel.inc      = m_tdata[63:48];
                rx_voxel.hit      = m_tuser[0];
                rx_voxel.too_long = m_tuser[1];
                rx_voxel.last     = m_tlast;
                board.check_result(rx_voxel);
            end
            if (hold_toggle != hold_ack)
            begin
                hold_ack  <= hold_toggle;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ray_voxel_traversal_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_ray(input ray_t r);
        if (!calm && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_tdata  <= r;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_ray(r);
    endtask

    task automatic send_points(input int sx, input int sy, input int sz,
                               input int ex, input int ey, input int ez);
        ray_t r;
        r.start_pt[0] = 16'(sx);
        r.start_pt[1] = 16'(sy);
        r.start_pt[2] = 16'(sz);
        r.end_pt[0]   = 16'(ex);
        r.end_pt[1]   = 16'(ey);
        r.end_pt[2]   = 16'(ez);
        send_ray(r);
    endtask

    // random start anywhere, end within reach on each axis
    function automatic ray_t offset_ray(input int reach);
        ray_t r;
        int   c;
        int   o;
        for (int k = 0; k < 3; k++)
        begin
            c = int'($urandom_range(65535)) - 32768;
            o = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(2 * reach)) - reach;
            if (c + o > 32767 || c + o < -32768)
                o = -o;
            r.start_pt[k] = 16'(c);
            r.end_pt[k]   = 16'(c + o);
        end
        return r;
    endfunction

    task automatic send_random(input int count);
        ray_t r;
        int   pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                r = offset_ray($urandom_range(8, 1));
            else if (pick < 85)
                r = offset_ray($urandom_range(MAX_SPAN, 1));
            else if (pick < 95)
                r = offset_ray($urandom_range(MAX_SPAN + 17, MAX_SPAN - 3));
            else
                r = {$urandom, $urandom, $urandom};
            send_ray(r);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rvt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rvt_pkg::FIELD_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, val);
    endtask

    task automatic set_increments(input logic [rvt_pkg::FIELD_W-1:0] free_val,
                                  input logic [rvt_pkg::FIELD_W-1:0] occ_val);
        drain();
        write_reg(rvt_pkg::REG_FREE_INC, free_val);
        write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
        write_reg(rvt_pkg::REG_OCC_INC, occ_val);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start equals end
        send_points(0, 0, 0, 0, 0, 0);
        send_points(-32768, 32767, -1, -32768, 32767, -1);
        // span at the limit and one past it
        send_points(0, 0, 0, 63, 10, -5);
        send_points(0, 0, 0, 64, 0, 0);
        send_points(0, 0, 0, 0, 0, -64);
        send_points(0, 0, 0, -30, -63, 20);
        // full range, both directions
        send_points(-32768, -32768, -32768, 32767, 32767, 32767);
        send_points(32767, 32767, 32767, -32768, -32768, -32768);
        // axis ties
        send_points(0, 0, 0, 5, 5, 2);
        send_points(0, 0, 0, -7, -7, -7);
        send_points(1, 1, 1, 3, 9, 9);
        send_points(0, 0, 0, 6, 1, -6);
        // x, y and z leads, zero minor components
        send_points(100, -100, 0, 90, -60, 5);
        send_points(-5, 3, 32760, -5, 3, 32700);
        send_points(10, 20, 30, -53, 20, 30);
        send_points(32700, 32767, -32768, 32763, 32730, -32705);
        send_points(0, 0, 0, 1, 0, 0);
        send_points(-1, -1, -1, 0, 0, 0);

        set_increments(16'h8000, 16'h7FFF);
        hold_toggle <= ~hold_toggle;
        send_random(90);

        set_increments(16'h7FFF, 16'h8000);
        calm <= 1'b1;
        send_random(45);
        drain();
        send_random(45);

        set_increments(16'h0000, 16'hFFFF);
        calm <= 1'b0;
        send_random(90);

        set_increments(16'($urandom), 16'($urandom));
        send_random(90);

        drain();
        if (board.errors == 0 && board.pending() == 0)
            $display("ray_voxel_traversal_tb OK");
        else
            $display("ray_voxel_traversal_tb NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rvt_pkg.sv
rtl/core/rvt_ctrl.sv
rtl/core/rvt_dp.sv
rtl/core/ray_voxel_traversal.sv
tb/ray_voxel_traversal_tb.sv
